// ===== src/btto_pkg.sv =====
// ----------------------------------------------------------------------------
// btto_pkg: shared types and constants of the box/triangle overlap test
// Queue status record, box-form enum and the cyclic axis successor and predecessor tables.
// ----------------------------------------------------------------------------
package btto_pkg;

	localparam int unsigned CNT_BITS = 4;

	typedef struct packed {
		logic                empty;
		logic [CNT_BITS-1:0] count;
	} btto_qstat_t;

	typedef enum logic {
		ACT_AABB = 1'b0,
		ACT_OBB  = 1'b1
	} btto_act_t;

	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

endpackage

// ===== src/btto_fifo.sv =====
// ----------------------------------------------------------------------------
// btto_fifo: small register queue
// First-in first-out store with status record; depth is a power of two.
// ----------------------------------------------------------------------------
module btto_fifo import btto_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output btto_qstat_t      stat
);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_BITS'(wr_en) - CNT_BITS'(rd_en);
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// ===== src/btto_front.sv =====
// ----------------------------------------------------------------------------
// btto_front: input classification and box-frame transform
// Brings the triangle into the box frame for either box form, two stages.
// ----------------------------------------------------------------------------
module btto_front import btto_pkg::*; #(
	parameter int C = 16,
	parameter int F = 14,
	localparam int A  = F + 2,
	localparam int WV = C + A + 3,
	localparam int WE = C + F + 1,
	localparam int PW = C + A + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       action,
	input  logic [47:0]                box_low,
	input  logic [47:0]                box_high,
	input  logic [47:0]                axis_one,
	input  logic [47:0]                axis_two,
	input  logic [47:0]                axis_three,
	input  logic [47:0]                vertex_a,
	input  logic [47:0]                vertex_b,
	input  logic [47:0]                vertex_c,
	output logic                       out_valid,
	output logic [2:0][2:0][WV-1:0]    out_v,
	output logic [2:0][WE-1:0]         out_e,
	output logic [1:0]                 busy
);

	logic [71:0]          lo_w, hi_w;
	logic [71:0]          row_w [3];
	logic [71:0]          t_w   [3];
	logic signed [C-1:0]  lo_f [3];
	logic signed [C-1:0]  hi_f [3];
	logic signed [C-1:0]  t_f  [3][3];
	logic signed [A-1:0]  r_f  [3][3];
	logic signed [C:0]    d_c  [3][3];
	logic signed [C+1:0]  v0_c [3][3];
	logic signed [C:0]    e0_c [3];
	logic signed [PW-1:0] p_c  [3][3][3];

	logic                 valid_s1;
	btto_act_t            act_s1;
	logic signed [C+1:0]  v0_s1 [3][3];
	logic signed [C:0]    e0_s1 [3];
	logic signed [C-1:0]  hi_s1 [3];
	logic signed [PW-1:0] p_s1  [3][3][3];

	// Unpack the coordinate and row words; fields above bit 47 read as zero.
	always_comb begin
		lo_w     = {24'd0, box_low};
		hi_w     = {24'd0, box_high};
		row_w[0] = {24'd0, axis_one};
		row_w[1] = {24'd0, axis_two};
		row_w[2] = {24'd0, axis_three};
		t_w[0]   = {24'd0, vertex_a};
		t_w[1]   = {24'd0, vertex_b};
		t_w[2]   = {24'd0, vertex_c};
		for (int k = 0; k < 3; k++) begin
			lo_f[k] = $signed(lo_w[k*C +: C]);
			hi_f[k] = $signed(hi_w[k*C +: C]);
			e0_c[k] = (C+1)'(hi_f[k]) - (C+1)'(lo_f[k]);
			for (int i = 0; i < 3; i++) begin
				t_f[i][k] = $signed(t_w[i][k*C +: C]);
				r_f[i][k] = $signed(row_w[i][k*A +: A]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				v0_c[i][k] = ((C+2)'(t_f[i][k]) <<< 1)
					- ((C+2)'(lo_f[k]) + (C+2)'(hi_f[k]));
				d_c[i][k]  = (C+1)'(t_f[i][k]) - (C+1)'(lo_f[k]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					p_c[i][k][j] = d_c[i][j] * r_f[k][j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= btto_act_t'(action);
		v0_s1  <= v0_c;
		e0_s1  <= e0_c;
		hi_s1  <= hi_f;
		p_s1   <= p_c;
		for (int k = 0; k < 3; k++) begin
			if (act_s1 == ACT_OBB) begin
				out_e[k] <= WE'(hi_s1[k]) <<< F;
			end else begin
				out_e[k] <= WE'(e0_s1[k]);
			end
			for (int i = 0; i < 3; i++) begin
				if (act_s1 == ACT_OBB) begin
					out_v[i][k] <= WV'(p_s1[i][k][0]) + WV'(p_s1[i][k][1])
						+ WV'(p_s1[i][k][2]);
				end else begin
					out_v[i][k] <= WV'(v0_s1[i][k]);
				end
			end
		end
	end

	assign busy = {out_valid, valid_s1};

endmodule

// ===== src/btto_back.sv =====
// ----------------------------------------------------------------------------
// btto_back: separating-axis evaluation
// Thirteen axis tests over four stages, wide products split in halves.
// ----------------------------------------------------------------------------
module btto_back import btto_pkg::*; #(
	parameter int C = 16,
	parameter int F = 14,
	localparam int A   = F + 2,
	localparam int WV  = C + A + 3,
	localparam int WE  = C + F + 1,
	localparam int WF  = WV + 1,
	localparam int WN  = 2 * WF + 1,
	localparam int HL  = (WN + 1) / 2,
	localparam int QW  = WV + WF,
	localparam int RW  = WE + WF + 1,
	localparam int NLW = WV + HL + 1,
	localparam int NHW = WV + WN - HL,
	localparam int ELW = WE + HL + 1,
	localparam int EHW = WE + WN - HL + 1,
	localparam int WX  = WV + WE + WN + 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [2:0][2:0][WV-1:0] in_v,
	input  logic [2:0][WE-1:0]      in_e,
	output logic                    out_valid,
	output logic                    overlap,
	output logic [3:0]              busy
);

	// Stage 1: edges, normal partial products, face tests
	logic signed [WV-1:0]   v_c  [3][3];
	logic signed [WE-1:0]   e_c  [3];
	logic signed [WF-1:0]   f_c  [3][3];
	logic signed [2*WF-1:0] pn_c [3][2];
	logic                   face_c;

	logic                   valid_s1, face_s1;
	logic signed [WV-1:0]   v_s1  [3][3];
	logic signed [WE-1:0]   e_s1  [3];
	logic signed [WF-1:0]   f_s1  [3][3];
	logic signed [2*WF-1:0] pn_s1 [3][2];

	always_comb begin
		face_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			e_c[k] = $signed(in_e[k]);
			for (int m = 0; m < 3; m++) begin
				v_c[m][k] = $signed(in_v[m][k]);
			end
		end
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				f_c[j][k] = WF'(v_c[NXT[j]][k]) - WF'(v_c[j][k]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			pn_c[k][0] = f_c[0][NXT[k]] * f_c[1][PRV[k]];
			pn_c[k][1] = f_c[0][PRV[k]] * f_c[1][NXT[k]];
			if ((v_c[0][k] > e_c[k] && v_c[1][k] > e_c[k] && v_c[2][k] > e_c[k])
				|| (v_c[0][k] < -(WE+1)'(e_c[k]) && v_c[1][k] < -(WE+1)'(e_c[k])
				&& v_c[2][k] < -(WE+1)'(e_c[k]))) begin
				face_c = 1'b1;
			end
		end
	end

	// Stage 2: normal, edge-axis projection and radius products
	logic signed [WN-1:0] n_c  [3];
	logic signed [WF:0]   af_c [3][3];
	logic signed [QW-1:0] q_c  [3][3][2][2];
	logic signed [RW-1:0] ra_c [3][3];
	logic signed [RW-1:0] rb_c [3][3];

	logic                 valid_s2, face_s2;
	logic signed [WN-1:0] n_s2  [3];
	logic signed [WV-1:0] v0_s2 [3];
	logic signed [WE-1:0] e_s2  [3];
	logic signed [QW-1:0] q_s2  [3][3][2][2];
	logic signed [RW-1:0] ra_s2 [3][3];
	logic signed [RW-1:0] rb_s2 [3][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_c[k] = WN'(pn_s1[k][0]) - WN'(pn_s1[k][1]);
		end
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				af_c[j][k] = f_s1[j][k][WF-1] ? -(WF+1)'(f_s1[j][k])
					: (WF+1)'(f_s1[j][k]);
			end
		end
		// Axis for box axis i and edge j is (-f_b) on a and (f_a) on b.
		// Both end points of edge j project alike, so two vertices suffice.
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				q_c[i][j][0][0] = v_s1[j][PRV[i]] * f_s1[j][NXT[i]];
				q_c[i][j][0][1] = v_s1[j][NXT[i]] * f_s1[j][PRV[i]];
				q_c[i][j][1][0] = v_s1[PRV[j]][PRV[i]] * f_s1[j][NXT[i]];
				q_c[i][j][1][1] = v_s1[PRV[j]][NXT[i]] * f_s1[j][PRV[i]];
				ra_c[i][j]      = e_s1[NXT[i]] * af_c[j][PRV[i]];
				rb_c[i][j]      = e_s1[PRV[i]] * af_c[j][NXT[i]];
			end
		end
	end

	// Stage 3: edge-axis comparisons, split normal products
	logic signed [QW:0]    pe_c [3][3][2];
	logic signed [RW:0]    re_c [3][3];
	logic                  edge_c;
	logic [WN-1:0]         an_c  [3];
	logic signed [NLW-1:0] nvl_c [3];
	logic signed [NHW-1:0] nvh_c [3];
	logic signed [ELW-1:0] erl_c [3];
	logic signed [EHW-1:0] erh_c [3];

	logic                  valid_s3, face_s3, edge_s3;
	logic signed [NLW-1:0] nvl_s3 [3];
	logic signed [NHW-1:0] nvh_s3 [3];
	logic signed [ELW-1:0] erl_s3 [3];
	logic signed [EHW-1:0] erh_s3 [3];

	always_comb begin
		edge_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int s = 0; s < 2; s++) begin
					pe_c[i][j][s] = (QW+1)'(q_s2[i][j][s][0])
						- (QW+1)'(q_s2[i][j][s][1]);
				end
				re_c[i][j] = (RW+1)'(ra_s2[i][j]) + (RW+1)'(rb_s2[i][j]);
				if ((pe_c[i][j][0] > re_c[i][j] && pe_c[i][j][1] > re_c[i][j])
					|| (pe_c[i][j][0] < -(RW+2)'(re_c[i][j])
					&& pe_c[i][j][1] < -(RW+2)'(re_c[i][j]))) begin
					edge_c = 1'b1;
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			an_c[k]  = n_s2[k][WN-1] ? WN'(-n_s2[k]) : WN'(n_s2[k]);
			nvl_c[k] = v0_s2[k] * $signed({1'b0, n_s2[k][HL-1:0]});
			nvh_c[k] = v0_s2[k] * $signed(n_s2[k][WN-1:HL]);
			erl_c[k] = e_s2[k] * $signed({1'b0, an_c[k][HL-1:0]});
			erh_c[k] = e_s2[k] * $signed({1'b0, an_c[k][WN-1:HL]});
		end
	end

	// Stage 4: triangle normal axis
	logic signed [WX-1:0] np_c, rn_c;
	logic                 norm_c;

	always_comb begin
		np_c = '0;
		rn_c = '0;
		for (int k = 0; k < 3; k++) begin
			np_c = np_c + (WX'(nvh_s3[k]) <<< HL) + WX'(nvl_s3[k]);
			rn_c = rn_c + (WX'(erh_s3[k]) <<< HL) + WX'(erl_s3[k]);
		end
		norm_c = (np_c > rn_c) || (np_c < -rn_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		face_s1 <= face_c;
		v_s1    <= v_c;
		e_s1    <= e_c;
		f_s1    <= f_c;
		pn_s1   <= pn_c;
		face_s2 <= face_s1;
		n_s2    <= n_c;
		v0_s2   <= v_s1[0];
		e_s2    <= e_s1;
		q_s2    <= q_c;
		ra_s2   <= ra_c;
		rb_s2   <= rb_c;
		face_s3 <= face_s2;
		edge_s3 <= edge_c;
		nvl_s3  <= nvl_c;
		nvh_s3  <= nvh_c;
		erl_s3  <= erl_c;
		erh_s3  <= erh_c;
		overlap <= !(face_s3 || edge_s3 || norm_c);
	end

	assign busy = {out_valid, valid_s3, valid_s2, valid_s1};

endmodule

// ===== src/box_triangle_overlap_test_core.sv =====
// ----------------------------------------------------------------------------
// box_triangle_overlap_test_core: box versus triangle overlap test
// Thirteen-axis separating-axis test on exact fixed-point arithmetic.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes front, middle queue, back and result
// queue before its result is visible, later while the result queue is held.
// Throughput: one transaction per cycle while full is low, set by the fully pipelined front
// transform and the four-stage axis evaluator.
// Reset: arst_n clears both queues and all stage valid bits; nothing else.
// ----------------------------------------------------------------------------
module box_triangle_overlap_test_core import btto_pkg::*; #(
	parameter int COORD_BITS     = 16,
	parameter int AXIS_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [47:0] box_low,
	input  logic [47:0] box_high,
	input  logic [47:0] axis_one,
	input  logic [47:0] axis_two,
	input  logic [47:0] axis_three,
	input  logic [47:0] vertex_a,
	input  logic [47:0] vertex_b,
	input  logic [47:0] vertex_c,
	output logic        empty,
	input  logic        pop,
	output logic        overlap
);

	// Internal widths follow from the coordinate and row formats.
	localparam int WV        = COORD_BITS + AXIS_FRAC_BITS + 5;
	localparam int WE        = COORD_BITS + AXIS_FRAC_BITS + 1;
	localparam int MID_W     = 9 * WV + 3 * WE;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	logic                    in_take;
	logic                    fr_valid;
	logic [2:0][2:0][WV-1:0] fr_v;
	logic [2:0][WE-1:0]      fr_e;
	logic [1:0]              fr_busy;
	logic [MID_W-1:0]        mid_rd;
	btto_qstat_t             mid_stat;
	logic                    mid_pop;
	logic                    bk_valid;
	logic                    bk_overlap;
	logic [3:0]              bk_busy;
	btto_qstat_t             out_stat;
	logic [CNT_BITS-1:0]     fr_inflight, bk_inflight;
	logic [2:0][2:0][WV-1:0] mid_v;
	logic [2:0][WE-1:0]      mid_e;

	// The front runs freely; a transaction is taken only while the middle
	// queue has room for it and for everything already inside the front.
	assign fr_inflight = CNT_BITS'(fr_busy[0]) + CNT_BITS'(fr_busy[1]);
	assign full        = (mid_stat.count + fr_inflight) >= CNT_BITS'(MID_DEPTH);
	assign in_take     = push && !full;

	btto_front #(
		.C (COORD_BITS),
		.F (AXIS_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_take),
		.action     (action),
		.box_low    (box_low),
		.box_high   (box_high),
		.axis_one   (axis_one),
		.axis_two   (axis_two),
		.axis_three (axis_three),
		.vertex_a   (vertex_a),
		.vertex_b   (vertex_b),
		.vertex_c   (vertex_c),
		.out_valid  (fr_valid),
		.out_v      (fr_v),
		.out_e      (fr_e),
		.busy       (fr_busy)
	);

	btto_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid),
		.wr_data ({fr_v, fr_e}),
		.rd_en   (mid_pop),
		.rd_data (mid_rd),
		.stat    (mid_stat)
	);

	assign {mid_v, mid_e} = mid_rd;

	// The back likewise never stalls; it draws from the middle queue only
	// when the result queue can hold every transaction in flight.
	assign bk_inflight = CNT_BITS'(bk_busy[0]) + CNT_BITS'(bk_busy[1])
		+ CNT_BITS'(bk_busy[2]) + CNT_BITS'(bk_busy[3]);
	assign mid_pop = !mid_stat.empty
		&& ((out_stat.count + bk_inflight) < CNT_BITS'(OUT_DEPTH));

	btto_back #(
		.C (COORD_BITS),
		.F (AXIS_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_pop),
		.in_v      (mid_v),
		.in_e      (mid_e),
		.out_valid (bk_valid),
		.overlap   (bk_overlap),
		.busy      (bk_busy)
	);

	btto_fifo #(
		.WIDTH (1),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bk_valid),
		.wr_data (bk_overlap),
		.rd_en   (pop && !out_stat.empty),
		.rd_data (overlap),
		.stat    (out_stat)
	);

	assign empty = out_stat.empty;

	// The credit scheme must keep the result queue from overflowing.
	a_out_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_stat.count + bk_inflight) <= CNT_BITS'(OUT_DEPTH))
		else $error("result queue credit exceeded");

	// The front must never deliver into a full middle queue.
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid |-> (mid_stat.count < CNT_BITS'(MID_DEPTH)))
		else $error("middle queue overrun");

	// An accepted transaction enters the front on the next cycle.
	a_take_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> fr_busy[0])
		else $error("accepted transaction lost at the front");

endmodule

// ===== dv/box_triangle_overlap_test_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_triangle_overlap_test_checker: result predictor and scoreboard
// Watches both queue interfaces, predicts the overlap flag of every accepted
// box/triangle pair with exact wide arithmetic, and compares in order.
// ----------------------------------------------------------------------------
module box_triangle_overlap_test_checker import btto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        action,
	input  logic [47:0] box_low,
	input  logic [47:0] box_high,
	input  logic [47:0] axis_one,
	input  logic [47:0] axis_two,
	input  logic [47:0] axis_three,
	input  logic [47:0] vertex_a,
	input  logic [47:0] vertex_b,
	input  logic [47:0] vertex_c,
	input  logic        empty,
	input  logic        pop,
	input  logic        overlap,
	output int          fails,
	output int          pending,
	output int          n_overlap,
	output int          n_apart
);

	typedef logic signed [159:0] wide_t;

	bit expected_overlap_q [$];

	initial begin
		fails     = 0;
		pending   = 0;
		n_overlap = 0;
		n_apart   = 0;
	end

	function automatic wide_t coord(input logic [47:0] wd, input int idx);
		logic signed [15:0] s;
		s = wd[idx*16 +: 16];
		return wide_t'(s);
	endfunction

	function automatic wide_t mag(input wide_t a);
		return (a < 0) ? -a : a;
	endfunction

	// True when the projected triangle lies strictly outside the box radius.
	function automatic bit splits(input wide_t v[9], input wide_t e[3],
	                              input wide_t a0, input wide_t a1, input wide_t a2);
		wide_t p [3];
		wide_t r, lo, hi;
		int i;
		for (i = 0; i < 3; i++)
			p[i] = v[i*3]*a0 + v[i*3+1]*a1 + v[i*3+2]*a2;
		r  = e[0]*mag(a0) + e[1]*mag(a1) + e[2]*mag(a2);
		lo = p[0];
		hi = p[0];
		for (i = 1; i < 3; i++) begin
			if (p[i] < lo) lo = p[i];
			if (p[i] > hi) hi = p[i];
		end
		return (lo > r) || (hi < -r);
	endfunction

	function automatic bit predict_overlap(input logic act,
	                                       input logic [47:0] lo, input logic [47:0] hi,
	                                       input logic [47:0] r0, input logic [47:0] r1,
	                                       input logic [47:0] r2, input logic [47:0] ta,
	                                       input logic [47:0] tb, input logic [47:0] tc);
		wide_t v [9];
		wide_t e [3];
		wide_t f [9];
		wide_t u [3];
		logic [47:0] tw [3];
		logic [47:0] rw [3];
		wide_t d0, d1, d2;
		int i, j, k;
		tw[0] = ta; tw[1] = tb; tw[2] = tc;
		rw[0] = r0; rw[1] = r1; rw[2] = r2;
		if (act == ACT_AABB) begin
			// Doubled scale keeps the centre integral.
			for (k = 0; k < 3; k++) begin
				e[k] = coord(hi, k) - coord(lo, k);
				for (i = 0; i < 3; i++)
					v[i*3+k] = 2*coord(tw[i], k) - (coord(lo, k) + coord(hi, k));
			end
		end else begin
			for (k = 0; k < 3; k++)
				e[k] = coord(hi, k) * (wide_t'(1) <<< 14);
			for (i = 0; i < 3; i++) begin
				d0 = coord(tw[i], 0) - coord(lo, 0);
				d1 = coord(tw[i], 1) - coord(lo, 1);
				d2 = coord(tw[i], 2) - coord(lo, 2);
				for (k = 0; k < 3; k++)
					v[i*3+k] = d0*coord(rw[k], 0) + d1*coord(rw[k], 1)
					         + d2*coord(rw[k], 2);
			end
		end
		for (k = 0; k < 3; k++) begin
			f[k]   = v[3+k] - v[k];
			f[3+k] = v[6+k] - v[3+k];
			f[6+k] = v[k]   - v[6+k];
		end
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++) begin
				for (k = 0; k < 3; k++) u[k] = wide_t'((i == k) ? 1 : 0);
				if (splits(v, e, u[1]*f[j*3+2] - u[2]*f[j*3+1],
				                 u[2]*f[j*3]   - u[0]*f[j*3+2],
				                 u[0]*f[j*3+1] - u[1]*f[j*3]))
					return 1'b0;
			end
		if (splits(v, e, wide_t'(1), wide_t'(0), wide_t'(0))
			|| splits(v, e, wide_t'(0), wide_t'(1), wide_t'(0))
			|| splits(v, e, wide_t'(0), wide_t'(0), wide_t'(1)))
			return 1'b0;
		if (splits(v, e, f[1]*f[5] - f[2]*f[4], f[2]*f[3] - f[0]*f[5],
		                 f[0]*f[4] - f[1]*f[3]))
			return 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fails++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				expected_overlap_q.push_back(predict_overlap(action, box_low, box_high,
					axis_one, axis_two, axis_three, vertex_a, vertex_b, vertex_c));
			if (pop && !empty) begin
				if (expected_overlap_q.size() == 0)
					report_mismatch("result transaction with nothing expected");
				else begin
					if (overlap !== expected_overlap_q[0])
						report_mismatch($sformatf("overlap %b, expected %b",
							overlap, expected_overlap_q[0]));
					if (expected_overlap_q[0]) n_overlap++;
					else n_apart++;
					void'(expected_overlap_q.pop_front());
				end
			end
			pending <= expected_overlap_q.size();
		end
	end

endmodule

// ===== dv/tb_box_triangle_overlap_test_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_triangle_overlap_test_core: testbench of the overlap test core
// Directed corner pairs then random near-box triangles of both box kinds,
// with bursty input, patterned output stalls and a checker beside the block.
// ----------------------------------------------------------------------------
module tb_box_triangle_overlap_test_core import btto_pkg::*;;

	localparam int RANDOM_PAIRS = 1400;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        action;
	logic [47:0] box_low, box_high, axis_one, axis_two, axis_three;
	logic [47:0] vertex_a, vertex_b, vertex_c;
	logic        empty;
	logic        pop;
	logic        overlap;

	int fails, pending, n_overlap, n_apart;
	int cycles;
	int n_aabb, n_obb;
	bit hold_request;

	box_triangle_overlap_test_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.box_low(box_low), .box_high(box_high), .axis_one(axis_one),
		.axis_two(axis_two), .axis_three(axis_three), .vertex_a(vertex_a),
		.vertex_b(vertex_b), .vertex_c(vertex_c), .empty(empty), .pop(pop),
		.overlap(overlap)
	);

	box_triangle_overlap_test_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.box_low(box_low), .box_high(box_high), .axis_one(axis_one),
		.axis_two(axis_two), .axis_three(axis_three), .vertex_a(vertex_a),
		.vertex_b(vertex_b), .vertex_c(vertex_c), .empty(empty), .pop(pop),
		.overlap(overlap), .fails(fails), .pending(pending),
		.n_overlap(n_overlap), .n_apart(n_apart)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a stuck handshake ends the run as a failure.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_box_triangle_overlap_test_core failed");
			$finish;
		end
	end

	// The receiver redraws its stall pattern periodically: always ready, ready
	// at random half the time, or ready at random a quarter of the time. Once the stimulus
	// asks for it, it also holds off for a long stretch so that the block's
	// queues fill and full is raised while the sender keeps offering.
	initial begin : receiver
		int hold_left;
		int mode;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		mode = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (cycles % 64 == 0) mode = $urandom_range(2);
			if (hold_request && !hold_done) begin
				hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(1));
					default: pop <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	function automatic logic [47:0] pack3(input int x, input int y, input int z);
		logic [15:0] a, b, c;
		a = 16'(x); b = 16'(y); c = 16'(z);
		return {c, b, a};
	endfunction

	function automatic logic [47:0] rnd_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic int rnd_in(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Offers one pair and waits until the block takes the transaction.
	task automatic offer_pair(input logic act, input logic [47:0] lo, input logic [47:0] hi,
	                          input logic [47:0] r0, input logic [47:0] r1,
	                          input logic [47:0] r2, input logic [47:0] ta,
	                          input logic [47:0] tb, input logic [47:0] tc);
		push       <= 1'b1;
		action     <= act;
		box_low    <= lo;
		box_high   <= hi;
		axis_one   <= r0;
		axis_two   <= r1;
		axis_three <= r2;
		vertex_a   <= ta;
		vertex_b   <= tb;
		vertex_c   <= tc;
		@(posedge clk);
		while (full) @(posedge clk);
		if (act == ACT_AABB) n_aabb++;
		else n_obb++;
	endtask

	task automatic idle_cycles(input int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Random pair: mostly a box with a triangle scattered around it so that
	// both outcomes are common; now and then every bit is random noise.
	task automatic offer_random_pair();
		int cx, cy, cz, hx, hy, hz, s, i;
		logic [47:0] tv [3];
		logic [47:0] rows [3];
		logic act;
		act = 1'($urandom_range(1));
		if ($urandom_range(9) == 0) begin
			offer_pair(act, rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
				rnd_word(), rnd_word(), rnd_word());
			return;
		end
		cx = rnd_in(-4000, 4000); cy = rnd_in(-4000, 4000); cz = rnd_in(-4000, 4000);
		hx = rnd_in(0, 400); hy = rnd_in(0, 400); hz = rnd_in(0, 400);
		if ($urandom_range(15) == 0) hx = -hx;
		s = 3 * (hx + hy + hz) / 2 + 20;
		for (i = 0; i < 3; i++)
			tv[i] = pack3(cx + rnd_in(-s, s), cy + rnd_in(-s, s), cz + rnd_in(-s, s));
		if (act == ACT_AABB) begin
			offer_pair(act, pack3(cx - hx, cy - hy, cz - hz), pack3(cx + hx, cy + hy, cz + hz),
				rnd_word(), rnd_word(), rnd_word(),
				tv[0], tv[1], tv[2]);
		end else begin
			if ($urandom_range(1)) begin
				// Signed permutation of the identity: a rotation or a reflection.
				s = $urandom_range(2);
				for (i = 0; i < 3; i++)
					rows[i] = pack3(((i + s) % 3 == 0) ? ($urandom_range(1) ? 16384 : -16384) : 0,
					                ((i + s) % 3 == 1) ? ($urandom_range(1) ? 16384 : -16384) : 0,
					                ((i + s) % 3 == 2) ? ($urandom_range(1) ? 16384 : -16384) : 0);
			end else begin
				for (i = 0; i < 3; i++)
					rows[i] = pack3(rnd_in(-32768, 32767), rnd_in(-32768, 32767),
					                rnd_in(-32768, 32767));
			end
			offer_pair(act, pack3(cx, cy, cz), pack3(hx, hy, hz),
				rows[0], rows[1], rows[2], tv[0], tv[1], tv[2]);
		end
	endtask

	initial begin : stimulus
		logic [47:0] id0, id1, id2, zero, maxp, minp;
		int sent, burst;
		id0  = pack3(16384, 0, 0);
		id1  = pack3(0, 16384, 0);
		id2  = pack3(0, 0, 16384);
		zero = '0;
		maxp = pack3(32767, 32767, 32767);
		minp = pack3(-32768, -32768, -32768);
		n_aabb = 0;
		n_obb = 0;
		hold_request = 0;
		arst_n     <= 1'b0;
		push       <= 1'b0;
		action     <= 1'b0;
		box_low    <= '0;
		box_high   <= '0;
		axis_one   <= '0;
		axis_two   <= '0;
		axis_three <= '0;
		vertex_a   <= '0;
		vertex_b   <= '0;
		vertex_c   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: triangle inside, beyond, just touching and just past a box face.
		offer_pair(ACT_AABB, pack3(-16, -16, -16), pack3(16, 16, 16), zero, zero, zero,
			pack3(0, 0, 0), pack3(8, 0, 0), pack3(0, 8, 0));
		offer_pair(ACT_AABB, pack3(-16, -16, -16), pack3(16, 16, 16), zero, zero, zero,
			pack3(40, 0, 0), pack3(48, 0, 0), pack3(40, 8, 0));
		offer_pair(ACT_AABB, pack3(-16, -16, -16), pack3(16, 16, 16), zero, zero, zero,
			pack3(16, 0, 0), pack3(30, 0, 0), pack3(16, 8, 0));
		offer_pair(ACT_AABB, pack3(-16, -16, -16), pack3(16, 16, 16), zero, zero, zero,
			pack3(17, 0, 0), pack3(30, 0, 0), pack3(17, 8, 0));
		// Large triangle whose plane misses the box corner: normal separates.
		offer_pair(ACT_AABB, pack3(0, 0, 0), pack3(16, 16, 16), zero, zero, zero,
			pack3(80, 0, 0), pack3(0, 80, 0), pack3(0, 0, 80));
		// Degenerate triangle: a single point, all edge axes vanish.
		offer_pair(ACT_AABB, pack3(0, 0, 0), pack3(16, 16, 16), zero, zero, zero,
			pack3(8, 8, 8), pack3(8, 8, 8), pack3(8, 8, 8));
		offer_pair(ACT_AABB, pack3(0, 0, 0), pack3(16, 16, 16), zero, zero, zero,
			pack3(40, 8, 8), pack3(40, 8, 8), pack3(40, 8, 8));
		// Inverted box: min above max.
		offer_pair(ACT_AABB, pack3(16, 16, 16), pack3(-16, -16, -16), zero, zero, zero,
			pack3(0, 0, 0), pack3(4, 0, 0), pack3(0, 4, 0));
		// Zero-size box and extremes of the coordinate range.
		offer_pair(ACT_AABB, zero, zero, zero, zero, zero, zero, zero, zero);
		offer_pair(ACT_AABB, minp, maxp, maxp, minp, maxp, maxp, minp, pack3(0, 32767, -32768));
		offer_pair(ACT_AABB, maxp, minp, minp, maxp, minp, minp, maxp, maxp);
		// Oriented boxes: identity frame, inside and outside.
		offer_pair(ACT_OBB, pack3(100, 100, 100), pack3(16, 16, 16), id0, id1, id2,
			pack3(100, 100, 100), pack3(110, 100, 100), pack3(100, 110, 100));
		offer_pair(ACT_OBB, pack3(100, 100, 100), pack3(16, 16, 16), id0, id1, id2,
			pack3(200, 100, 100), pack3(210, 100, 100), pack3(200, 110, 100));
		// Rotated frame, negative half-size, all-zero rows, extreme rows.
		offer_pair(ACT_OBB, pack3(0, 0, 0), pack3(16, 16, 16), id1, pack3(-16384, 0, 0), id2,
			pack3(20, 0, 0), pack3(20, 5, 0), pack3(20, 0, 5));
		offer_pair(ACT_OBB, pack3(0, 0, 0), pack3(-16, 16, 16), id0, id1, id2,
			pack3(0, 0, 0), pack3(4, 0, 0), pack3(0, 4, 0));
		offer_pair(ACT_OBB, pack3(0, 0, 0), pack3(16, 16, 16), zero, zero, zero,
			pack3(500, 0, 0), pack3(504, 0, 0), pack3(500, 4, 0));
		offer_pair(ACT_OBB, minp, maxp, maxp, minp, pack3(32767, -32768, 0),
			maxp, minp, pack3(-32768, 32767, 0));
		offer_pair(ACT_OBB, maxp, minp, minp, maxp, minp, minp, maxp, zero);
		idle_cycles(1);

		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < RANDOM_PAIRS) begin
				offer_random_pair();
				sent++;
				burst--;
				if (sent == RANDOM_PAIRS / 3) hold_request = 1;
				// End the burst here so that the drain below is reached.
				if (sent == RANDOM_PAIRS * 2 / 3) burst = 0;
			end
			if (sent == RANDOM_PAIRS * 2 / 3) begin
				// Let the block drain completely before carrying on.
				push <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 8));
		end
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d axis-aligned and %0d oriented pairs", n_aabb, n_obb);
		$display("results: %0d overlapping, %0d separated, %0d mismatches",
			n_overlap, n_apart, fails);
		if (fails == 0)
			$display("tb_box_triangle_overlap_test_core passed");
		else
			$display("tb_box_triangle_overlap_test_core failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/btto_pkg.sv
src/btto_fifo.sv
src/btto_front.sv
src/btto_back.sv
src/box_triangle_overlap_test_core.sv
dv/box_triangle_overlap_test_checker.sv
dv/tb_box_triangle_overlap_test_core.sv
